FILE: src/gbr_pkg.sv
package gbr_pkg;

  localparam int PIN_W        = 20;
  localparam int CODE_W       = 6;
  localparam int PINS_PER_REG = 10;
  localparam int MAP_W        = CODE_W * PINS_PER_REG;
  localparam int CFG_IDX_W    = 2;
  localparam int CTX_W        = 3;
  localparam int DIR_W        = 4;
  localparam int AXIS_W       = 8;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 48;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_HIGH = 2'd3;

  // Function codes.
  localparam logic [CODE_W-1:0] CODE_UP        = 6'd1;
  localparam logic [CODE_W-1:0] CODE_DOWN      = 6'd2;
  localparam logic [CODE_W-1:0] CODE_LEFT      = 6'd3;
  localparam logic [CODE_W-1:0] CODE_RIGHT     = 6'd4;
  localparam logic [CODE_W-1:0] CODE_SQUARE    = 6'd5;
  localparam logic [CODE_W-1:0] CODE_CROSS     = 6'd6;
  localparam logic [CODE_W-1:0] CODE_CIRCLE    = 6'd7;
  localparam logic [CODE_W-1:0] CODE_TRIANGLE  = 6'd8;
  localparam logic [CODE_W-1:0] CODE_L1        = 6'd9;
  localparam logic [CODE_W-1:0] CODE_R1        = 6'd10;
  localparam logic [CODE_W-1:0] CODE_L2        = 6'd11;
  localparam logic [CODE_W-1:0] CODE_R2        = 6'd12;
  localparam logic [CODE_W-1:0] CODE_SELECT    = 6'd13;
  localparam logic [CODE_W-1:0] CODE_START     = 6'd14;
  localparam logic [CODE_W-1:0] CODE_L3        = 6'd15;
  localparam logic [CODE_W-1:0] CODE_R3        = 6'd16;
  localparam logic [CODE_W-1:0] CODE_LS_UP     = 6'd17;
  localparam logic [CODE_W-1:0] CODE_LS_DOWN   = 6'd18;
  localparam logic [CODE_W-1:0] CODE_LS_LEFT   = 6'd19;
  localparam logic [CODE_W-1:0] CODE_LS_RIGHT  = 6'd20;
  localparam logic [CODE_W-1:0] CODE_RESTRICT  = 6'd21;
  localparam logic [CODE_W-1:0] CODE_INV_Y     = 6'd22;
  localparam logic [CODE_W-1:0] CODE_AF_SQUARE = 6'd23;
  localparam logic [CODE_W-1:0] CODE_AF_CROSS  = 6'd24;
  localparam logic [CODE_W-1:0] CODE_AF_CIRCLE = 6'd25;
  localparam logic [CODE_W-1:0] CODE_AF_TRI    = 6'd26;
  localparam logic [CODE_W-1:0] CODE_RS_UP     = 6'd29;
  localparam logic [CODE_W-1:0] CODE_RS_DOWN   = 6'd30;
  localparam logic [CODE_W-1:0] CODE_RS_LEFT   = 6'd31;
  localparam logic [CODE_W-1:0] CODE_RS_RIGHT  = 6'd32;

  // Direction bit positions in the d-pad word.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // Direction contexts: none, or the direction output last (index plus one).
  localparam logic [CTX_W-1:0] CTX_NONE  = 3'd0;
  localparam logic [CTX_W-1:0] CTX_UP    = 3'd1;
  localparam logic [CTX_W-1:0] CTX_DOWN  = 3'd2;
  localparam logic [CTX_W-1:0] CTX_LEFT  = 3'd3;
  localparam logic [CTX_W-1:0] CTX_RIGHT = 3'd4;

  localparam logic [AXIS_W-1:0] AXIS_REST = 8'h7F;
  localparam logic [AXIS_W-1:0] AXIS_MIN  = 8'h00;
  localparam logic [AXIS_W-1:0] AXIS_MAX  = 8'hFF;

  typedef struct packed {
    logic              inv_y;
    logic              restrict4;
    logic              autofire;
    logic [DIR_W-1:0]  dirs;
    logic [3:0]        face;
    logic [3:0]        af_face;
    logic [5:0]        shoulder;
    logic [1:0]        sys;
    logic              ly_hit;
    logic              ly_pos;
    logic              lx_hit;
    logic              lx_pos;
    logic              ry_hit;
    logic              ry_pos;
    logic              rx_hit;
    logic              rx_pos;
  } lane_t;

  typedef struct packed {
    logic [AXIS_W-1:0] right_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] left_x;
    logic [1:0]        system_buttons;
    logic [5:0]        shoulder_buttons;
    logic [3:0]        face_buttons;
    logic [DIR_W-1:0]  dpad;
  } result_t;

  // Priority order of directions for a context, first choice in bits 1:0.
  function automatic logic [7:0] dir_order(input logic [CTX_W-1:0] ctx);
    logic [7:0] ord;
    case (ctx)
      CTX_UP:    ord = {DIR_UP, DIR_RIGHT, DIR_LEFT, DIR_DOWN};
      CTX_DOWN:  ord = {DIR_DOWN, DIR_RIGHT, DIR_LEFT, DIR_UP};
      CTX_LEFT:  ord = {DIR_LEFT, DIR_DOWN, DIR_UP, DIR_RIGHT};
      default:   ord = {DIR_RIGHT, DIR_DOWN, DIR_UP, DIR_LEFT};
    endcase
    return ord;
  endfunction

endpackage

FILE: src/gamepad_button_remapper.sv
// Channel | Handshake          | Payload
// in_     | in_tvalid/tready   | tdata: pins_n; tuser: shifted
// out_    | out_tvalid/tready  | tdata: dpad .. right_y
// cfg_    | cfg_we             | cfg_index, cfg_wdata (60-bit code map)
//
// One poll per cycle while out_tready keeps the output free; the pin lanes
// decode into a register, then the merge stage updates the direction and
// autofire state and loads the output register.
// Reset (synchronous, rst_n low) clears the maps and state, autofire phase on.
// While a result waits at the output, the lane register takes one more request
// and then holds in_tready low until out_tready frees the output register.
module gamepad_button_remapper
  import gbr_pkg::*;
#(
  parameter int NUM_PINS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pins_n [19:0], zero pad [23:20]
  input  logic                  in_tuser,   // shifted
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // dpad, face_buttons, shoulder_buttons,
                                            // system_buttons, left_x, left_y,
                                            // right_x, right_y
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [MAP_W-1:0]      cfg_wdata
);

  logic [MAP_W-1:0]     map_pl_r, map_ph_r, map_sl_r, map_sh_r;
  lane_t [NUM_PINS-1:0] lanes;
  lane_t [NUM_PINS-1:0] lanes_r;
  logic                 lanes_valid_r;
  logic                 advance;
  result_t              res;
  logic [PIN_W-1:0]     pins_n;

  assign pins_n    = in_tdata[PIN_W-1:0];
  assign in_tready = !lanes_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_pl_r <= '0;
      map_ph_r <= '0;
      map_sl_r <= '0;
      map_sh_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLAIN_LOW:  map_pl_r <= cfg_wdata;
        CFG_PLAIN_HIGH: map_ph_r <= cfg_wdata;
        CFG_SHIFT_LOW:  map_sl_r <= cfg_wdata;
        CFG_SHIFT_HIGH: map_sh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_PINS; i++) begin : g_lane
    localparam int SLOT = i % PINS_PER_REG;
    logic [CODE_W-1:0] code_plain;
    logic [CODE_W-1:0] code_shift;

    if (i < PINS_PER_REG) begin : g_low
      assign code_plain = map_pl_r[SLOT*CODE_W +: CODE_W];
      assign code_shift = map_sl_r[SLOT*CODE_W +: CODE_W];
    end else begin : g_high
      assign code_plain = map_ph_r[SLOT*CODE_W +: CODE_W];
      assign code_shift = map_sh_r[SLOT*CODE_W +: CODE_W];
    end

    gbr_lane u_lane (
      .pressed    (!pins_n[i]),
      .code_plain (code_plain),
      .code_sel   (in_tuser ? code_shift : code_plain),
      .lane       (lanes[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lanes_valid_r <= 1'b0;
    end else if (in_tready) begin
      lanes_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      lanes_r <= lanes;
    end
  end

  gbr_merge #(
    .NUM_PINS (NUM_PINS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .lanes_valid (lanes_valid_r),
    .lanes       (lanes_r),
    .advance     (advance),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .res         (res)
  );

  assign out_tdata = {res.right_y, res.right_x, res.left_y, res.left_x,
                      res.system_buttons, res.shoulder_buttons,
                      res.face_buttons, res.dpad};

endmodule

FILE: src/gbr_lane.sv
module gbr_lane
  import gbr_pkg::*;
(
  input  logic              pressed,
  input  logic [CODE_W-1:0] code_plain,
  input  logic [CODE_W-1:0] code_sel,
  output lane_t             lane
);

  always_comb begin
    lane = '0;
    if (pressed) begin
      // Restrict and invert also react to the unshifted assignment.
      lane.inv_y     = (code_plain == CODE_INV_Y) || (code_sel == CODE_INV_Y);
      lane.restrict4 = (code_plain == CODE_RESTRICT) || (code_sel == CODE_RESTRICT);
      case (code_sel)
        CODE_UP:        lane.dirs[DIR_UP]    = 1'b1;
        CODE_DOWN:      lane.dirs[DIR_DOWN]  = 1'b1;
        CODE_LEFT:      lane.dirs[DIR_LEFT]  = 1'b1;
        CODE_RIGHT:     lane.dirs[DIR_RIGHT] = 1'b1;
        CODE_SQUARE:    lane.face[0]     = 1'b1;
        CODE_CROSS:     lane.face[1]     = 1'b1;
        CODE_CIRCLE:    lane.face[2]     = 1'b1;
        CODE_TRIANGLE:  lane.face[3]     = 1'b1;
        CODE_L1:        lane.shoulder[0] = 1'b1;
        CODE_R1:        lane.shoulder[1] = 1'b1;
        CODE_L2:        lane.shoulder[2] = 1'b1;
        CODE_R2:        lane.shoulder[3] = 1'b1;
        CODE_L3:        lane.shoulder[4] = 1'b1;
        CODE_R3:        lane.shoulder[5] = 1'b1;
        CODE_SELECT:    lane.sys[0]      = 1'b1;
        CODE_START:     lane.sys[1]      = 1'b1;
        CODE_LS_UP:     lane.ly_hit      = 1'b1;
        CODE_LS_DOWN: begin
          lane.ly_hit = 1'b1;
          lane.ly_pos = 1'b1;
        end
        CODE_LS_LEFT:   lane.lx_hit      = 1'b1;
        CODE_LS_RIGHT: begin
          lane.lx_hit = 1'b1;
          lane.lx_pos = 1'b1;
        end
        CODE_RS_UP:     lane.ry_hit      = 1'b1;
        CODE_RS_DOWN: begin
          lane.ry_hit = 1'b1;
          lane.ry_pos = 1'b1;
        end
        CODE_RS_LEFT:   lane.rx_hit      = 1'b1;
        CODE_RS_RIGHT: begin
          lane.rx_hit = 1'b1;
          lane.rx_pos = 1'b1;
        end
        CODE_AF_SQUARE: begin
          lane.autofire   = 1'b1;
          lane.af_face[0] = 1'b1;
        end
        CODE_AF_CROSS: begin
          lane.autofire   = 1'b1;
          lane.af_face[1] = 1'b1;
        end
        CODE_AF_CIRCLE: begin
          lane.autofire   = 1'b1;
          lane.af_face[2] = 1'b1;
        end
        CODE_AF_TRI: begin
          lane.autofire   = 1'b1;
          lane.af_face[3] = 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/gbr_merge.sv
module gbr_merge
  import gbr_pkg::*;
#(
  parameter int NUM_PINS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 lanes_valid,
  input  lane_t [NUM_PINS-1:0] lanes,
  output logic                 advance,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output result_t              res
);

  logic             out_valid_r;
  result_t          res_r;
  result_t          res_nxt;
  logic [DIR_W-1:0] last_dirs_r;
  logic [CTX_W-1:0] ctx_r;
  logic [CTX_W-1:0] ctx_nxt;
  logic [CTX_W-1:0] saved_ctx_r;
  logic [CTX_W-1:0] saved_ctx_nxt;
  logic             phase_r;
  logic             phase_nxt;

  logic             inv_y;
  logic             restrict4;
  logic             autofire;
  logic [DIR_W-1:0] dirs;
  logic [3:0]       face;
  logic [3:0]       af_face;
  logic [5:0]       shoulder;
  logic [1:0]       sys;
  logic             ly_hit, ly_pos, lx_hit, lx_pos;
  logic             ry_hit, ry_pos, rx_hit, rx_pos;
  logic [CTX_W-1:0] ctx_eff;
  logic [7:0]       ord;
  logic [1:0]       dir_k;
  logic             found;

  assign advance = lanes_valid && (!out_valid_r || out_tready);

  always_comb begin
    inv_y     = 1'b0;
    restrict4 = 1'b0;
    autofire  = 1'b0;
    dirs      = '0;
    face      = '0;
    af_face   = '0;
    shoulder  = '0;
    sys       = '0;
    ly_hit = 1'b0; ly_pos = 1'b0; lx_hit = 1'b0; lx_pos = 1'b0;
    ry_hit = 1'b0; ry_pos = 1'b0; rx_hit = 1'b0; rx_pos = 1'b0;
    for (int i = 0; i < NUM_PINS; i++) begin
      inv_y     = inv_y | lanes[i].inv_y;
      restrict4 = restrict4 | lanes[i].restrict4;
      autofire  = autofire | lanes[i].autofire;
      dirs      = dirs | lanes[i].dirs;
      face      = face | lanes[i].face;
      af_face   = af_face | lanes[i].af_face;
      shoulder  = shoulder | lanes[i].shoulder;
      sys       = sys | lanes[i].sys;
      // Later lanes override earlier ones: the highest pin decides an axis.
      if (lanes[i].ly_hit) begin
        ly_hit = 1'b1;
        ly_pos = lanes[i].ly_pos;
      end
      if (lanes[i].lx_hit) begin
        lx_hit = 1'b1;
        lx_pos = lanes[i].lx_pos;
      end
      if (lanes[i].ry_hit) begin
        ry_hit = 1'b1;
        ry_pos = lanes[i].ry_pos;
      end
      if (lanes[i].rx_hit) begin
        rx_hit = 1'b1;
        rx_pos = lanes[i].rx_pos;
      end
    end

    // The phase flips before it gates the autofire buttons of this poll.
    phase_nxt = phase_r ^ autofire;

    res_nxt.dpad             = dirs;
    res_nxt.face_buttons     = face | (phase_nxt ? af_face : 4'b0000);
    res_nxt.shoulder_buttons = shoulder;
    res_nxt.system_buttons   = sys;
    res_nxt.left_x  = lx_hit ? (lx_pos ? AXIS_MAX : AXIS_MIN) : AXIS_REST;
    res_nxt.left_y  = ly_hit ? ((ly_pos ^ inv_y) ? AXIS_MAX : AXIS_MIN) : AXIS_REST;
    res_nxt.right_x = rx_hit ? (rx_pos ? AXIS_MAX : AXIS_MIN) : AXIS_REST;
    res_nxt.right_y = ry_hit ? ((ry_pos ^ inv_y) ? AXIS_MAX : AXIS_MIN) : AXIS_REST;

    // Four-way: an unchanged request restores the saved context, so a held
    // diagonal keeps the direction it started with.
    ctx_eff       = (dirs == last_dirs_r) ? saved_ctx_r : ctx_r;
    ord           = dir_order(ctx_eff);
    found         = 1'b0;
    dir_k         = DIR_UP;
    ctx_nxt       = ctx_r;
    saved_ctx_nxt = saved_ctx_r;
    if (restrict4) begin
      res_nxt.dpad  = '0;
      saved_ctx_nxt = ctx_eff;
      ctx_nxt       = ctx_eff;
      if (ctx_eff <= CTX_RIGHT) begin
        for (int k = 0; k < 4; k++) begin
          dir_k = ord[2*k +: 2];
          if (!found && dirs[dir_k]) begin
            found                = 1'b1;
            res_nxt.dpad[dir_k]  = 1'b1;
            ctx_nxt              = CTX_W'(dir_k) + CTX_UP;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_dirs_r <= '0;
      ctx_r       <= CTX_NONE;
      saved_ctx_r <= CTX_NONE;
      phase_r     <= 1'b1;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        last_dirs_r <= dirs;
        ctx_r       <= ctx_nxt;
        saved_ctx_r <= saved_ctx_nxt;
        phase_r     <= phase_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign res        = res_r;

`ifndef SYNTHESIS
  a_dpad_single: assert property (@(posedge clk) disable iff (!rst_n)
    advance && restrict4 |=> $onehot0(res_r.dpad))
    else $error("four-way mode produced more than one direction");

  a_ctx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r <= CTX_RIGHT && saved_ctx_r <= CTX_RIGHT)
    else $error("direction context out of range");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && autofire) |=> $stable(phase_r))
    else $error("autofire phase changed without an autofire press");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(last_dirs_r) && $stable(ctx_r) && $stable(saved_ctx_r))
    else $error("direction state changed without a poll");
`endif

endmodule
